// ===== src/ads_pkg.sv =====
// types and constants shared by the antenna deployment sequencer modules
package ads_pkg;

    localparam logic [2:0] PH_STARTUP = 3'd0;
    localparam logic [2:0] PH_DELAY   = 3'd1;
    localparam logic [2:0] PH_ALG1    = 3'd2;
    localparam logic [2:0] PH_ALG2    = 3'd3;
    localparam logic [2:0] PH_RADIO_A = 3'd4;
    localparam logic [2:0] PH_RADIO_B = 3'd5;
    localparam logic [2:0] PH_DONE    = 3'd6;

    localparam logic [2:0] ACT_NONE  = 3'd0;
    localparam logic [2:0] ACT_ALG1  = 3'd1;
    localparam logic [2:0] ACT_ALG2  = 3'd2;
    localparam logic [2:0] ACT_REL_A = 3'd3;
    localparam logic [2:0] ACT_REL_B = 3'd4;

    localparam logic [1:0] CFG_SEPARATION_WAIT = 2'd0;
    localparam logic [1:0] CFG_ATTEMPT_WAIT    = 2'd1;
    localparam logic [1:0] CFG_OPEN_CODE       = 2'd2;

    typedef struct packed {
        logic [31:0] now_ms;
        logic [7:0]  status_byte;
    } in_word_t;

    typedef struct packed {
        logic [2:0] action;
        logic [2:0] phase;
        logic       deployed;
        logic       cycle_done;
    } out_word_t;

    typedef struct packed {
        logic [31:0] separation_wait_ms;
        logic [31:0] attempt_wait_ms;
        logic [7:0]  open_code;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  phase;
        logic [31:0] start_ms;
        logic        deployed;
        logic        done;
    } seq_state_t;

endpackage

// ===== src/ads_step.sv =====
// next-state and result logic for one poll of the deployment sequencer
module ads_step
    import ads_pkg::*;
(
    input  seq_state_t state,
    input  cfg_t       cfg,
    input  in_word_t   word,
    output seq_state_t state_next,
    output out_word_t  result
);

    logic [31:0] elapsed;
    logic        sep_timeout;
    logic        att_timeout;
    logic        is_open;
    logic [2:0]  action;

    assign elapsed     = word.now_ms - state.start_ms;
    assign sep_timeout = elapsed >= cfg.separation_wait_ms;
    assign att_timeout = elapsed >= cfg.attempt_wait_ms;
    assign is_open     = word.status_byte == cfg.open_code;

    always_comb begin
        state_next = state;
        action     = ACT_NONE;
        case (state.phase)
            PH_STARTUP: begin
                state_next.phase    = PH_DELAY;
                state_next.start_ms = word.now_ms;
            end
            PH_DELAY: begin
                if (sep_timeout) begin
                    action              = ACT_ALG1;
                    state_next.phase    = PH_ALG1;
                    state_next.start_ms = word.now_ms;
                end
            end
            PH_ALG1, PH_ALG2, PH_RADIO_A, PH_RADIO_B: begin
                if (att_timeout) begin
                    state_next.start_ms = word.now_ms;
                    if (is_open) begin
                        state_next.phase    = PH_DONE;
                        state_next.deployed = 1'b1;
                        state_next.done     = 1'b1;
                    end else begin
                        case (state.phase)
                            PH_ALG1: begin
                                action           = ACT_ALG2;
                                state_next.phase = PH_ALG2;
                            end
                            PH_ALG2: begin
                                action           = ACT_REL_A;
                                state_next.phase = PH_RADIO_A;
                            end
                            PH_RADIO_A: begin
                                action           = ACT_REL_B;
                                state_next.phase = PH_RADIO_B;
                            end
                            default: begin
                                state_next.phase    = PH_DONE;
                                state_next.deployed = 1'b0;
                                state_next.done     = 1'b1;
                            end
                        endcase
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign result.action     = action;
    assign result.phase      = state_next.phase;
    assign result.deployed   = state_next.deployed;
    assign result.cycle_done = state_next.done;

endmodule

// ===== src/antenna_deploy_sequencer_top.sv =====
// top level of the antenna deployment sequencer: config registers, state and result register
// Each accepted word is one poll and yields one result word in the next cycle; a poll
// is taken every cycle as long as the result register is empty or being drained, so the
// sustained rate is one word per clock. The result word is registered after the
// single-pass step logic (one 32-bit subtract, two 32-bit compares and an 8-bit match).
module antenna_deploy_sequencer_top
    import ads_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_word_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_word_t   m_data
);

    cfg_t       cfg_reg;
    seq_state_t state_reg;
    seq_state_t state_next;
    out_word_t  result_next;
    out_word_t  out_reg;
    logic       m_valid_reg;
    logic       accept;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    ads_step u_step (
        .state      (state_reg),
        .cfg        (cfg_reg),
        .word       (s_data),
        .state_next (state_next),
        .result     (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg     <= '0;
            state_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_SEPARATION_WAIT: cfg_reg.separation_wait_ms <= cfg_wdata;
                    CFG_ATTEMPT_WAIT:    cfg_reg.attempt_wait_ms    <= cfg_wdata;
                    CFG_OPEN_CODE:       cfg_reg.open_code          <= cfg_wdata[7:0];
                    default: begin
                    end
                endcase
            end
            if (accept) begin
                state_reg   <= state_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_reg <= result_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // done flag tracks the completed phase
    a_done_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.done == (state_reg.phase == PH_DONE))
        else $error("done flag and phase disagree");

    a_deployed_done: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.deployed |-> state_reg.done)
        else $error("deployed without done");

    // an issued action always lands in the phase it starts
    a_action_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.action != ACT_NONE) |-> m_data.phase == 3'(m_data.action + 3'd1))
        else $error("action does not match phase");

    a_accept_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid)
        else $error("accepted word produced no result");

endmodule

// ===== verif/deploy_seq_checker.sv =====
// antenna deploy sequencer checker: predicts each poll's result word and compares it on the output
`timescale 1ns / 1ps

module deploy_seq_checker
    import ads_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    input  logic        s_ready,
    input  in_word_t    s_data,
    input  logic        m_valid,
    input  logic        m_ready,
    input  out_word_t   m_data,
    output int          errors,
    output int          pending,
    output int          polls_seen,
    output int          results_seen
);

    cfg_t        settings;
    logic [2:0]  phase_q;
    logic [31:0] start_ms_q;
    logic        deployed_q;
    logic        done_q;
    out_word_t   expected_results[$];
    out_word_t   want_word;

    function automatic out_word_t advance_sequence(in_word_t poll);
        logic [31:0] elapsed;
        logic [2:0]  act;
        out_word_t   r;
        elapsed = poll.now_ms - start_ms_q;
        act = ACT_NONE;
        case (phase_q)
            PH_STARTUP: begin
                phase_q = PH_DELAY;
                start_ms_q = poll.now_ms;
            end
            PH_DELAY: begin
                if (elapsed >= settings.separation_wait_ms) begin
                    act = ACT_ALG1;
                    phase_q = PH_ALG1;
                    start_ms_q = poll.now_ms;
                end
            end
            PH_ALG1, PH_ALG2, PH_RADIO_A, PH_RADIO_B: begin
                if (elapsed >= settings.attempt_wait_ms) begin
                    start_ms_q = poll.now_ms;
                    if (poll.status_byte == settings.open_code) begin
                        phase_q = PH_DONE;
                        deployed_q = 1'b1;
                        done_q = 1'b1;
                    end else begin
                        case (phase_q)
                            PH_ALG1: begin
                                act = ACT_ALG2;
                                phase_q = PH_ALG2;
                            end
                            PH_ALG2: begin
                                act = ACT_REL_A;
                                phase_q = PH_RADIO_A;
                            end
                            PH_RADIO_A: begin
                                act = ACT_REL_B;
                                phase_q = PH_RADIO_B;
                            end
                            default: begin
                                phase_q = PH_DONE;
                                deployed_q = 1'b0;
                                done_q = 1'b1;
                            end
                        endcase
                    end
                end
            end
            default: ;
        endcase
        r.action = act;
        r.phase = phase_q;
        r.deployed = deployed_q;
        r.cycle_done = done_q;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input out_word_t want, input out_word_t got);
        errors++;
        if (errors <= 10) begin
            $display("%0t: %s: expected action %0d phase %0d deployed %0b done %0b",
                     $realtime, what, want.action, want.phase, want.deployed, want.cycle_done);
            $display("%0t: %s: actual   action %0d phase %0d deployed %0b done %0b",
                     $realtime, what, got.action, got.phase, got.deployed, got.cycle_done);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            settings = '0;
            phase_q = PH_STARTUP;
            start_ms_q = '0;
            deployed_q = 1'b0;
            done_q = 1'b0;
            expected_results.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_SEPARATION_WAIT: settings.separation_wait_ms = cfg_wdata;
                    CFG_ATTEMPT_WAIT:    settings.attempt_wait_ms = cfg_wdata;
                    CFG_OPEN_CODE:       settings.open_code = cfg_wdata[7:0];
                    default: ;
                endcase
            end
            // drain first so an empty queue is seen before this cycle's poll is added
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected word", '0, m_data);
                end else begin
                    want_word = expected_results.pop_front();
                    if (m_data.action !== want_word.action || m_data.phase !== want_word.phase ||
                        m_data.deployed !== want_word.deployed ||
                        m_data.cycle_done !== want_word.cycle_done) begin
                        report_mismatch("result mismatch", want_word, m_data);
                    end
                end
            end
            if (s_valid && s_ready) begin
                expected_results.push_back(advance_sequence(s_data));
                polls_seen++;
            end
        end
        pending = expected_results.size();
    end

endmodule

// ===== verif/tb.sv =====
// testbench top for the antenna deploy sequencer: clock, reset, poll stimulus and verdict
`timescale 1ns / 1ps

module tb;
    import ads_pkg::*;

    localparam int HOLD_CYCLES    = 200;
    localparam int WATCHDOG_LIMIT = 2000;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = CFG_SEPARATION_WAIT;
    logic [31:0] cfg_wdata = '0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    in_word_t    s_data    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    out_word_t   m_data;

    int   errors;
    int   pending;
    int   polls_seen;
    int   results_seen;
    int   idle_cycles = 0;
    bit   steady = 1'b0;
    bit   hold_off_req = 1'b0;
    bit   deploy_end;

    antenna_deploy_sequencer_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    deploy_seq_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .errors       (errors),
        .pending      (pending),
        .polls_seen   (polls_seen),
        .results_seen (results_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_poll(input logic [31:0] now, input logic [7:0] status);
        int gap;
        s_valid <= 1'b1;
        s_data <= {now, status};
        do @(posedge aclk); while (!s_ready);
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic write_cfg(input logic [31:0] sep, input logic [31:0] att,
                             input logic [7:0] code);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_SEPARATION_WAIT;
        cfg_wdata <= sep;
        @(posedge aclk);
        cfg_index <= CFG_ATTEMPT_WAIT;
        cfg_wdata <= att;
        @(posedge aclk);
        cfg_index <= CFG_OPEN_CODE;
        cfg_wdata <= {24'd0, code};
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        repeat (4) @(posedge aclk);
    endtask

    // receiver side: random ready gaps, plus one long hold-off on request
    initial begin
        int gap;
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                gap = pick_gap();
                m_ready <= (gap == 0);
                repeat ((gap == 0) ? 1 : gap) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin : stimulus
        logic [31:0] anchor;
        logic [31:0] att;
        logic [31:0] sep;
        logic [31:0] off;
        logic [7:0]  code;
        logic [7:0]  status;
        int          n;

        deploy_end = 1'($urandom_range(0, 1));
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // all-ones waits: only an elapsed time of exactly 2^32-1 times out
        write_cfg(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
        anchor = 32'hFFFF_FFF0;
        send_poll(anchor, 8'h00);
        send_poll(32'hFFFF_FFFF, 8'hFF);
        send_poll(32'h0000_0000, 8'hFF);
        send_poll(anchor + 32'hFFFF_FFFE, 8'hA5);
        anchor = anchor - 32'd1;
        send_poll(anchor, 8'h5A);
        send_poll(anchor, 8'hFF);
        send_poll(anchor + 32'hFFFF_FFFE, 8'hFF);
        wait_idle();

        att = 32'h8000_0000;
        code = 8'h00;
        write_cfg(32'h0000_0000, att, code);
        send_poll(anchor + 32'h7FFF_FFFF, 8'h00);

        // one stage per attempt method: in-window polls (none in stage 2), then the timeout poll
        for (int stage = 0; stage < 4; stage++) begin
            if (stage > 0) begin
                wait_idle();
                case (stage)
                    1: begin
                        sep = $urandom;
                        att = $urandom | 32'h1;
                        code = 8'($urandom_range(0, 255));
                    end
                    2: begin
                        sep = 32'hFFFF_FFFF;
                        att = 32'h0;
                        code = 8'h00;
                    end
                    default: begin
                        sep = 32'h0;
                        att = $urandom_range(1, 5000);
                        code = 8'($urandom_range(0, 255));
                    end
                endcase
                write_cfg(sep, att, code);
                if (stage == 1) hold_off_req = 1'b1;
            end
            n = (stage == 2) ? 0 : ((stage == 3) ? 180 : 150);
            for (int i = 0; i < n; i++) begin
                if (i % 40 == 0) steady = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 7) == 0)
                    off = att - 32'd1;
                else
                    off = $urandom_range(0, att - 32'd1);
                status = ($urandom_range(0, 7) == 0) ? code : 8'($urandom_range(0, 255));
                send_poll(anchor + off, status);
            end
            steady = 1'b0;
            off = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom_range(0, ~att);
            if (stage == 3 && deploy_end)
                status = code;
            else
                status = code ^ 8'($urandom_range(1, 255));
            anchor = anchor + att + off;
            send_poll(anchor, status);
        end

        // sequence has finished; further polls must leave it unchanged
        for (int i = 0; i < 20; i++)
            send_poll($urandom, 8'($urandom_range(0, 255)));
        wait_idle();

        $display("run: %0d polls sent, %0d result words compared, one %0d-cycle output hold-off",
                 polls_seen, results_seen, HOLD_CYCLES);
        $display("deployment stepped through all four methods and ended %s",
                 deploy_end ? "deployed" : "failed");
        if (errors == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== antenna_deploy_sequencer_top.f =====
src/ads_pkg.sv
src/ads_step.sv
src/antenna_deploy_sequencer_top.sv
verif/deploy_seq_checker.sv
verif/tb.sv
